[rtl/supply_trend_hysteresis_monitor_macros.svh]
// Assertion macros of the supply trend monitor checker.
`ifndef SUPPLY_TREND_HYSTERESIS_MONITOR_MACROS_SVH
`define SUPPLY_TREND_HYSTERESIS_MONITOR_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define STHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define STHM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sthm_pkg.sv]
// Types and constants of the supply trend hysteresis monitor.
package sthm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SHIFT_W    = 3;
    localparam int TREND_W    = 14;
    localparam int FORECAST_W = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef logic [SAMPLE_W-1:0]          sample_t;
    typedef logic [SHIFT_W-1:0]           shift_t;
    typedef logic signed [TREND_W-1:0]    trend_t;
    typedef logic signed [FORECAST_W-1:0] forecast_t;
    typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NORMAL = 2'd1,
        ACT_LOW    = 2'd2
    } action_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_HIGH_THRESHOLD = 3'd0;
    localparam cfg_idx_t CFG_LOW_THRESHOLD  = 3'd1;
    localparam cfg_idx_t CFG_LEVEL_SHIFT    = 3'd2;
    localparam cfg_idx_t CFG_TREND_SHIFT    = 3'd3;
    localparam cfg_idx_t CFG_FORECAST_SHIFT = 3'd4;
    localparam cfg_idx_t CFG_START_LEVEL    = 3'd5;

    // Reset values of the configuration registers
    localparam sample_t RST_HIGH_THRESHOLD = 12'h0E00;
    localparam sample_t RST_LOW_THRESHOLD  = 12'h0C00;
    localparam shift_t  RST_LEVEL_SHIFT    = 3'd1;
    localparam shift_t  RST_TREND_SHIFT    = 3'd5;
    localparam shift_t  RST_FORECAST_SHIFT = 3'd3;
    localparam sample_t RST_START_LEVEL    = 12'h0800;

endpackage

[rtl/sthm_in_if.sv]
// Input channel: one supply sample and the link flag per transaction.
interface sthm_in_if;
    import sthm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    link_open;

    modport source (output valid, output sample, output link_open, input ready);
    modport sink   (input valid, input sample, input link_open, output ready);
endinterface

[rtl/sthm_out_if.sv]
// Output channel: power mode, action and forecast per transaction.
interface sthm_out_if;
    import sthm_pkg::*;

    logic      valid;
    logic      ready;
    logic      power_low;
    action_t   action;
    forecast_t forecast;

    modport source (output valid, output power_low, output action, output forecast,
                    input ready);
    modport sink   (input valid, input power_low, input action, input forecast,
                    output ready);
endinterface

[rtl/supply_trend_hysteresis_monitor.sv]
// Supply trend monitor: smoothed level and trend, forecast, hysteretic power mode.
//
// Usage:
//   in_ch carries one 12-bit supply sample and a link_open flag per transaction;
//   out_ch returns one result per sample: power_low, action and the signed
//   21-bit forecast. Thresholds, smoothing shifts and the start level are set
//   through the write port (cfg_wr_en, cfg_index, cfg_data) while no sample is
//   in flight.
// Path: a sample taken from in_ch passes the input register and then the
//   output register, from which it is presented on out_ch.
// Throughput: one sample per cycle unless out_ch stalls. The input register
//   feeds a single pass of shifts, adds and two compares that updates the
//   averages and the mode and loads the output register in the same cycle.
// Stall: while out_ch is stalled the result holds; an empty input register still
//   takes one more sample from in_ch, then ready drops until the output moves.
// Reset: rst_n (asynchronous, active low) restores the default configuration,
//   clears both averages, the first-sample flag and the mode (normal), and
//   drops all pending transactions.
module supply_trend_hysteresis_monitor (
    input  logic                 clk,
    input  logic                 rst_n,
    sthm_in_if.sink              in_ch,
    sthm_out_if.source           out_ch,
    input  logic                 cfg_wr_en,
    input  sthm_pkg::cfg_idx_t   cfg_index,
    input  sthm_pkg::cfg_data_t  cfg_data
);
    import sthm_pkg::*;

    // configuration
    sample_t high_threshold_reg;
    sample_t low_threshold_reg;
    shift_t  level_shift_reg;
    shift_t  trend_shift_reg;
    shift_t  forecast_shift_reg;
    sample_t start_level_reg;

    // state
    sample_t level_avg_reg;
    trend_t  trend_avg_reg;
    sample_t prev_sample_reg;
    logic    seen_any_reg;
    logic    mode_low_reg;

    // input register
    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    s1_link_reg;

    // output register
    logic      out_valid_reg;
    logic      out_power_low_reg;
    action_t   out_action_reg;
    forecast_t out_forecast_reg;

    logic out_advance;
    logic s1_fire;
    logic in_fire;

    sample_t                last_sample;
    logic signed [12:0]     diff;
    logic [19:0]            level_sum;
    sample_t                level_next;
    logic signed [21:0]     trend_wide;
    logic signed [21:0]     trend_sum;
    trend_t                 trend_next;
    logic signed [21:0]     forecast_wide;
    logic                   above_high;
    logic                   below_low;
    logic                   mode_low_next;
    action_t                action_next;

    assign out_advance  = !out_valid_reg || out_ch.ready;
    assign s1_fire      = s1_valid_reg && out_advance;
    assign in_ch.ready  = !s1_valid_reg || out_advance;
    assign in_fire      = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.power_low = out_power_low_reg;
    assign out_ch.action    = out_action_reg;
    assign out_ch.forecast  = out_forecast_reg;

    always_comb
    begin
        last_sample = seen_any_reg ? prev_sample_reg : start_level_reg;
        diff        = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, last_sample});

        // (a << k) - a + x, then >> k; never negative
        level_sum  = ({8'b0, level_avg_reg} << level_shift_reg) - {8'b0, level_avg_reg}
                     + {8'b0, s1_sample_reg};
        level_next = 12'(level_sum >> level_shift_reg);

        // same update on the signed trend, arithmetic shift gives the floor
        trend_wide = {{8{trend_avg_reg[TREND_W-1]}}, trend_avg_reg};
        trend_sum  = (trend_wide <<< trend_shift_reg) - trend_wide
                     + {{9{diff[12]}}, diff};
        trend_next = TREND_W'(trend_sum >>> trend_shift_reg);

        forecast_wide = $signed({10'b0, level_next})
                        + ($signed({{8{trend_next[TREND_W-1]}}, trend_next})
                           <<< forecast_shift_reg);

        above_high = forecast_wide > $signed({10'b0, high_threshold_reg});
        below_low  = forecast_wide < $signed({10'b0, low_threshold_reg});

        // high test wins when the thresholds are crossed
        mode_low_next = mode_low_reg;
        action_next   = ACT_NONE;
        if (above_high)
        begin
            if (mode_low_reg)
            begin
                mode_low_next = 1'b0;
                action_next   = s1_link_reg ? ACT_NORMAL : ACT_NONE;
            end
        end
        else if (below_low)
        begin
            if (!mode_low_reg)
            begin
                mode_low_next = 1'b1;
                action_next   = s1_link_reg ? ACT_LOW : ACT_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= RST_HIGH_THRESHOLD;
            low_threshold_reg  <= RST_LOW_THRESHOLD;
            level_shift_reg    <= RST_LEVEL_SHIFT;
            trend_shift_reg    <= RST_TREND_SHIFT;
            forecast_shift_reg <= RST_FORECAST_SHIFT;
            start_level_reg    <= RST_START_LEVEL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data;
                CFG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data;
                CFG_LEVEL_SHIFT:    level_shift_reg    <= cfg_data[SHIFT_W-1:0];
                CFG_TREND_SHIFT:    trend_shift_reg    <= cfg_data[SHIFT_W-1:0];
                CFG_FORECAST_SHIFT: forecast_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_START_LEVEL:    start_level_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_avg_reg   <= '0;
            trend_avg_reg   <= '0;
            prev_sample_reg <= '0;
            seen_any_reg    <= 1'b0;
            mode_low_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                level_avg_reg   <= level_next;
                trend_avg_reg   <= trend_next;
                prev_sample_reg <= s1_sample_reg;
                seen_any_reg    <= 1'b1;
                mode_low_reg    <= mode_low_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= in_ch.sample;
            s1_link_reg   <= in_ch.link_open;
        end
        if (s1_fire)
        begin
            out_power_low_reg <= mode_low_next;
            out_action_reg    <= action_next;
            out_forecast_reg  <= FORECAST_W'(forecast_wide);
        end
    end

endmodule

[rtl/sthm_checker.sv]
// Port-level checks of the supply trend monitor, bound to the top level.
`include "supply_trend_hysteresis_monitor_macros.svh"

module sthm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              power_low,
    input sthm_pkg::action_t action,
    input sthm_pkg::forecast_t forecast
);
    import sthm_pkg::*;

    // an action always names the mode that was just entered
    `STHM_ASSERT(a_action_matches_mode, (out_valid && action != ACT_NONE) |-> (power_low == (action == ACT_LOW)), "action disagrees with power_low")

    `STHM_ASSERT(a_action_code, out_valid |-> (action == ACT_NONE || action == ACT_NORMAL || action == ACT_LOW), "undefined action code")

    // stalled result keeps its value
    `STHM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(power_low) && $stable(action) && $stable(forecast)), "stalled result changed")

    `STHM_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind supply_trend_hysteresis_monitor sthm_checker u_sthm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .power_low (out_ch.power_low),
    .action    (out_ch.action),
    .forecast  (out_ch.forecast)
);
